FILE: sv/edf_tick_scheduler_top_defines.svh
// Assertion macros for the scheduler top level.
`ifndef EDF_TICK_SCHEDULER_TOP_DEFINES_SVH
`define EDF_TICK_SCHEDULER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define EDF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("edf scheduler check failed");
`define EDF_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("edf scheduler check failed");
`else
`define EDF_ASSERT(lbl, prop)
`define EDF_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: sv/edf_pkg.sv
package edf_pkg;

    localparam int MAX_TASKS_DEF = 16;

    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_LOAD    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic [4:0] TASK_COUNT_RST = 5'd1;

    localparam logic signed [17:0] CD_MIN = 18'sh20000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH,
        S_REPLY
    } state_t;

    typedef struct packed {
        logic load_we;
        logic restart;
        logic best_clear;
        logic rd_en;
        logic finish;
        logic reply;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic none_active;
    } ctrl_stat_t;

endpackage

FILE: sv/edf_ifs.sv
interface edf_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [3:0]  task_index;
    logic [15:0] exec_time;
    logic [15:0] period_len;
    logic [15:0] rel_deadline;

    modport source (output valid, cmd, task_index, exec_time, period_len, rel_deadline,
                    input ready);
    modport sink (input valid, cmd, task_index, exec_time, period_len, rel_deadline,
                  output ready);
endinterface

interface edf_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] tick_time;
    logic [3:0]  running_task;
    logic        idle;

    modport source (output valid, tick_time, running_task, idle, input ready);
    modport sink (input valid, tick_time, running_task, idle, output ready);
endinterface

FILE: sv/edf_ctrl.sv
module edf_ctrl #(
    parameter int MAX_TASKS = edf_pkg::MAX_TASKS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    req_valid,
    input  logic [1:0]                              req_cmd,
    output logic                                    req_ready,
    input  edf_pkg::ctrl_stat_t                     stat,
    input  logic [$clog2(MAX_TASKS+1)-1:0]          active_n,
    output edf_pkg::ctrl_cmd_t                      ctrl,
    output logic [(MAX_TASKS > 1 ? $clog2(MAX_TASKS) : 1)-1:0] rd_addr
);

    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int IDX_W = MAX_TASKS > 1 ? $clog2(MAX_TASKS) : 1;

    edf_pkg::state_t   state_reg, state_next;
    logic [CNT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]  scan_inc;
    logic              scan_last;

    assign scan_inc  = scan_idx_reg + CNT_W'(1);
    assign scan_last = (scan_inc == active_n);
    assign rd_addr   = scan_idx_reg[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= edf_pkg::S_IDLE;
            scan_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        case (state_reg)
            edf_pkg::S_IDLE:
            begin
                scan_idx_next = '0;
                if (req_valid)
                begin
                    if (req_cmd == edf_pkg::CMD_TICK)
                        state_next = stat.none_active ? edf_pkg::S_FINISH : edf_pkg::S_SCAN;
                    else
                        state_next = edf_pkg::S_REPLY;
                end
            end
            edf_pkg::S_SCAN:
            begin
                scan_idx_next = scan_inc;
                if (scan_last)
                    state_next = edf_pkg::S_DRAIN;
            end
            edf_pkg::S_DRAIN:
                state_next = edf_pkg::S_FINISH;
            edf_pkg::S_FINISH, edf_pkg::S_REPLY:
            begin
                if (stat.out_free)
                    state_next = edf_pkg::S_IDLE;
            end
            default:
                state_next = edf_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl      = '0;
        req_ready = 1'b0;
        case (state_reg)
            edf_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    case (req_cmd)
                        edf_pkg::CMD_TICK:    ctrl.best_clear = 1'b1;
                        edf_pkg::CMD_LOAD:    ctrl.load_we    = 1'b1;
                        edf_pkg::CMD_RESTART: ctrl.restart    = 1'b1;
                        default:              ctrl            = '0;
                    endcase
                end
            end
            edf_pkg::S_SCAN:   ctrl.rd_en  = 1'b1;
            edf_pkg::S_FINISH: ctrl.finish = stat.out_free;
            edf_pkg::S_REPLY:  ctrl.reply  = stat.out_free;
            default:           ctrl        = '0;
        endcase
    end

endmodule

FILE: sv/edf_dpath.sv
module edf_dpath #(
    parameter int MAX_TASKS = edf_pkg::MAX_TASKS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  edf_pkg::ctrl_cmd_t                      ctrl,
    input  logic [(MAX_TASKS > 1 ? $clog2(MAX_TASKS) : 1)-1:0] rd_addr,
    input  logic                                    cfg_we,
    input  logic [4:0]                              cfg_wdata,
    input  logic [3:0]                              task_index,
    input  logic [15:0]                             exec_time,
    input  logic [15:0]                             period_len,
    input  logic [15:0]                             rel_deadline,
    output edf_pkg::ctrl_stat_t                     stat,
    output logic [$clog2(MAX_TASKS+1)-1:0]          active_n,
    input  logic                                    rsp_ready,
    output logic                                    rsp_valid,
    output logic [31:0]                             tick_time,
    output logic [3:0]                              running_task,
    output logic                                    idle
);

    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int IDX_W = MAX_TASKS > 1 ? $clog2(MAX_TASKS) : 1;

    // task tables
    logic [15:0] exec_mem   [MAX_TASKS];
    logic [15:0] period_mem [MAX_TASKS];
    logic [15:0] dl_mem     [MAX_TASKS];
    // run state
    logic [15:0]        work_mem  [MAX_TASKS];
    logic [15:0]        phase_mem [MAX_TASKS];
    logic signed [17:0] cd_mem    [MAX_TASKS];
    logic [MAX_TASKS-1:0] run_vld_reg;

    logic [4:0]  task_count_reg;
    logic [31:0] time_reg;

    logic [15:0]        exec_rd_reg, period_rd_reg, dl_rd_reg, work_rd_reg, phase_rd_reg;
    logic signed [17:0] cd_rd_reg;
    logic               vld_rd_reg;
    logic               wb_pend_reg;
    logic [IDX_W-1:0]   wb_idx_reg;

    logic               best_found_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic signed [17:0] best_cd_reg;
    logic [15:0]        best_work_reg;

    logic        rsp_valid_reg;
    logic [31:0] tick_time_reg;
    logic [3:0]  running_reg;
    logic        idle_reg;

    logic               tbl_we;
    logic [IDX_W-1:0]   tbl_waddr;
    logic [15:0]        w_cur, ph_cur, w_rel, ph_new;
    logic signed [17:0] cd_cur, cd_rel, cd_new;
    logic [16:0]        ph_inc;
    logic               released, take;
    logic               work_we;
    logic [IDX_W-1:0]   work_waddr;
    logic [15:0]        work_wdata;

    assign tbl_we    = ctrl.load_we && (32'(task_index) < 32'(MAX_TASKS));
    assign tbl_waddr = IDX_W'(task_index);

    assign active_n = (32'(task_count_reg) > 32'(MAX_TASKS)) ? CNT_W'(MAX_TASKS)
                                                             : CNT_W'(task_count_reg);
    assign stat.none_active = (active_n == '0);
    assign stat.out_free    = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            task_count_reg <= edf_pkg::TASK_COUNT_RST;
        else if (cfg_we)
            task_count_reg <= cfg_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            exec_mem[tbl_waddr]   <= exec_time;
            period_mem[tbl_waddr] <= period_len;
            dl_mem[tbl_waddr]     <= rel_deadline;
        end
        if (ctrl.rd_en)
        begin
            exec_rd_reg   <= exec_mem[rd_addr];
            period_rd_reg <= period_mem[rd_addr];
            dl_rd_reg     <= dl_mem[rd_addr];
            work_rd_reg   <= work_mem[rd_addr];
            phase_rd_reg  <= phase_mem[rd_addr];
            cd_rd_reg     <= cd_mem[rd_addr];
            vld_rd_reg    <= run_vld_reg[rd_addr];
            wb_idx_reg    <= rd_addr;
        end
    end

    // release, selection and countdown update for the entry read last cycle
    always_comb
    begin
        w_cur    = vld_rd_reg ? work_rd_reg  : '0;
        ph_cur   = vld_rd_reg ? phase_rd_reg : '0;
        cd_cur   = vld_rd_reg ? cd_rd_reg    : '0;
        released = (ph_cur == '0);
        w_rel    = released ? exec_rd_reg : w_cur;
        cd_rel   = released ? $signed({2'b00, dl_rd_reg}) : cd_cur;
        take     = (w_rel != '0) && (!best_found_reg || (cd_rel < best_cd_reg));
        cd_new   = (cd_rel == edf_pkg::CD_MIN) ? cd_rel : cd_rel - 18'sd1;
        ph_inc   = {1'b0, ph_cur} + 17'd1;
        ph_new   = (ph_inc >= {1'b0, period_rd_reg}) ? '0 : ph_inc[15:0];
    end

    assign work_we    = wb_pend_reg || (ctrl.finish && best_found_reg);
    assign work_waddr = wb_pend_reg ? wb_idx_reg : best_idx_reg;
    assign work_wdata = wb_pend_reg ? w_rel : best_work_reg - 16'd1;

    always_ff @(posedge clk)
    begin
        if (work_we)
            work_mem[work_waddr] <= work_wdata;
        if (wb_pend_reg)
        begin
            phase_mem[wb_idx_reg] <= ph_new;
            cd_mem[wb_idx_reg]    <= cd_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_vld_reg    <= '0;
            wb_pend_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            time_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            wb_pend_reg <= ctrl.rd_en;
            if (ctrl.restart)
                run_vld_reg <= '0;
            else if (wb_pend_reg)
                run_vld_reg[wb_idx_reg] <= 1'b1;

            if (ctrl.best_clear)
                best_found_reg <= 1'b0;
            else if (wb_pend_reg && take)
                best_found_reg <= 1'b1;

            if (ctrl.restart)
                time_reg <= '0;
            else if (ctrl.finish)
                time_reg <= time_reg + 32'd1;

            if (ctrl.finish || ctrl.reply)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wb_pend_reg && take)
        begin
            best_idx_reg  <= wb_idx_reg;
            best_cd_reg   <= cd_rel;
            best_work_reg <= w_rel;
        end
        if (ctrl.finish)
        begin
            tick_time_reg <= time_reg;
            running_reg   <= best_found_reg ? 4'(best_idx_reg) : 4'd0;
            idle_reg      <= !best_found_reg;
        end
        else if (ctrl.reply)
        begin
            tick_time_reg <= time_reg;
            running_reg   <= 4'd0;
            idle_reg      <= 1'b1;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign tick_time    = tick_time_reg;
    assign running_task = running_reg;
    assign idle         = idle_reg;

endmodule

FILE: sv/edf_tick_scheduler_top.sv
// Earliest-deadline-first scheduler for periodic tasks.
// req carries one command per beat: tick, load a task entry, or restart.
// rsp returns exactly one beat per req beat, in order: the tick time, the
// task that ran and an idle flag (idle is set for every non-tick command).
// cfg_we/cfg_wdata write the active task count; write it only while idle.
// A tick reads the table once per active task through the per-task
// memories (S_SCAN), drains the read pipeline (S_DRAIN) and commits the
// winner (S_FINISH), which registers its rsp beat. Load, restart and
// unused commands go straight to S_REPLY, and a tick with no active task
// straight to S_FINISH; either registers the rsp beat. The controller then
// returns to S_IDLE for the next req beat.
// req.ready is high only while the controller waits for a command.
// rsp is a single output register: a new command is still accepted while
// a beat waits, and the block holds in its final cycle until rsp drains.
// Reset clears run state, time and the output register and sets the task
// count to one; task tables hold garbage until loaded.
`include "edf_tick_scheduler_top_defines.svh"

module edf_tick_scheduler_top #(
    parameter int MAX_TASKS = edf_pkg::MAX_TASKS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    edf_req_if.sink     req,
    edf_rsp_if.source   rsp,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int IDX_W = MAX_TASKS > 1 ? $clog2(MAX_TASKS) : 1;

    edf_pkg::ctrl_cmd_t  ctrl;
    edf_pkg::ctrl_stat_t stat;
    logic [CNT_W-1:0]    active_n;
    logic [IDX_W-1:0]    rd_addr;

    edf_ctrl #(
        .MAX_TASKS (MAX_TASKS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_cmd   (req.cmd),
        .req_ready (req.ready),
        .stat      (stat),
        .active_n  (active_n),
        .ctrl      (ctrl),
        .rd_addr   (rd_addr)
    );

    edf_dpath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .rd_addr      (rd_addr),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .task_index   (req.task_index),
        .exec_time    (req.exec_time),
        .period_len   (req.period_len),
        .rel_deadline (req.rel_deadline),
        .stat         (stat),
        .active_n     (active_n),
        .rsp_ready    (rsp.ready),
        .rsp_valid    (rsp.valid),
        .tick_time    (rsp.tick_time),
        .running_task (rsp.running_task),
        .idle         (rsp.idle)
    );

    `EDF_ASSERT_ALWAYS(a_one_cmd, $onehot0(ctrl))
    `EDF_ASSERT(a_no_accept_in_scan, ctrl.rd_en |-> !req.ready)
    `EDF_ASSERT(a_commit_slot_free, (ctrl.finish || ctrl.reply) |-> stat.out_free)
    `EDF_ASSERT(a_scan_in_range, ctrl.rd_en |-> (CNT_W'(rd_addr) < active_n))

endmodule

FILE: tb/sv/edf_tick_scheduler_top_test.sv
`timescale 1ns / 1ps

module edf_tick_scheduler_top_test;

    localparam int          NTASK      = edf_pkg::MAX_TASKS_DEF;
    localparam logic [1:0]  CMD_UNUSED = 2'd3;
    localparam int          SETTLE     = NTASK + 4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  idx;
        logic [15:0] exec_len;
        logic [15:0] period;
        logic [15:0] deadline;
    } sched_cmd_t;

    typedef struct packed {
        logic [31:0] tick_time;
        logic [3:0]  task_id;
        logic        idle;
    } sched_slot_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [4:0] cfg_wdata;

    edf_req_if req_if();
    edf_rsp_if rsp_if();

    edf_tick_scheduler_top #(.MAX_TASKS(NTASK)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // scheduler shadow state
    logic [15:0]        exec_tab  [NTASK];
    logic [15:0]        period_tab[NTASK];
    logic [15:0]        dl_tab    [NTASK];
    logic [15:0]        work_rem  [NTASK];
    logic [15:0]        phase_ctr [NTASK];
    logic signed [17:0] dl_count  [NTASK];
    logic [31:0]        now_tick;
    logic [4:0]         active_lim;
    bit                 loaded    [NTASK];

    sched_slot_t pending_slots[$];
    int miss_count = 0;
    int gap_pct    = 20;
    int stall_pct  = 20;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("edf_tick_scheduler_top_test: FAIL");
        $finish;
    end

    function automatic void clear_run_state();
        for (int i = 0; i < NTASK; i++)
        begin
            work_rem[i]  = '0;
            phase_ctr[i] = '0;
            dl_count[i]  = '0;
        end
        now_tick = '0;
    endfunction

    function automatic sched_slot_t advance_schedule(sched_cmd_t c);
        sched_slot_t r;
        int          n;
        int          pick;
        logic [16:0] nxt;
        r.tick_time = now_tick;
        r.task_id   = '0;
        r.idle      = 1'b1;
        pick        = -1;
        case (c.cmd)
            edf_pkg::CMD_LOAD:
            begin
                exec_tab[c.idx]   = c.exec_len;
                period_tab[c.idx] = c.period;
                dl_tab[c.idx]     = c.deadline;
                loaded[c.idx]     = 1'b1;
            end
            edf_pkg::CMD_RESTART:
            begin
                clear_run_state();
                r.tick_time = '0;
            end
            edf_pkg::CMD_TICK:
            begin
                n = (active_lim > NTASK) ? NTASK : int'(active_lim);
                for (int i = 0; i < n; i++)
                begin
                    if (phase_ctr[i] == 0)
                    begin
                        work_rem[i] = exec_tab[i];
                        dl_count[i] = $signed({2'b00, dl_tab[i]});
                    end
                end
                for (int i = 0; i < n; i++)
                begin
                    if (work_rem[i] != 0 && (pick < 0 || dl_count[i] < dl_count[pick]))
                        pick = i;
                end
                if (pick >= 0)
                begin
                    work_rem[pick] = work_rem[pick] - 16'd1;
                    r.task_id      = 4'(pick);
                    r.idle         = 1'b0;
                end
                for (int i = 0; i < n; i++)
                begin
                    if (dl_count[i] > edf_pkg::CD_MIN)
                        dl_count[i] = dl_count[i] - 18'sd1;
                    nxt = {1'b0, phase_ctr[i]} + 17'd1;
                    if (nxt >= {1'b0, period_tab[i]})
                        nxt = '0;
                    phase_ctr[i] = nxt[15:0];
                end
                now_tick = now_tick + 32'd1;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic log_miss(string what, logic [31:0] want, logic [31:0] got);
        miss_count++;
        if (miss_count <= 10)
            $display("mismatch %s: expected 0x%0h got 0x%0h at %0t", what, want, got, $time);
    endtask

    always @(posedge clk)
    begin : rsp_check
        sched_slot_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_slots.size() == 0)
                log_miss("unexpected beat, tick_time", '0, rsp_if.tick_time);
            else
            begin
                want = pending_slots.pop_front();
                if (rsp_if.tick_time !== want.tick_time)
                    log_miss("tick_time", want.tick_time, rsp_if.tick_time);
                if (rsp_if.running_task !== want.task_id)
                    log_miss("running_task", want.task_id, rsp_if.running_task);
                if (rsp_if.idle !== want.idle)
                    log_miss("idle", want.idle, rsp_if.idle);
            end
        end
    end

    // result-side backpressure
    initial
    begin : rsp_stall
        int hold_left;
        hold_left    = 0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
                    hold_left = $urandom_range(1, 16);
            end
        end
    end

    // called just after a falling edge; returns just after a falling edge
    task automatic send_item(logic [1:0] cmd, logic [3:0] idx, logic [15:0] ex,
                             logic [15:0] pe, logic [15:0] dl);
        sched_cmd_t c;
        c = '{cmd: cmd, idx: idx, exec_len: ex, period: pe, deadline: dl};
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.cmd          <= c.cmd;
        req_if.task_index   <= c.idx;
        req_if.exec_time    <= c.exec_len;
        req_if.period_len   <= c.period;
        req_if.rel_deadline <= c.deadline;
        do
            @(posedge clk);
        while (!req_if.ready);
        pending_slots.push_back(advance_schedule(c));
        @(negedge clk);
    endtask

    task automatic send_tick();
        send_item(edf_pkg::CMD_TICK, 4'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (pending_slots.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_task_count(logic [4:0] val);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        active_lim = val;
    endtask

    function automatic logic [15:0] shaped_value(int lo, int hi);
        if ($urandom_range(0, 7) == 0)
            return 16'($urandom);
        return 16'($urandom_range(lo, hi));
    endfunction

    task automatic send_rand_load(logic [3:0] idx);
        send_item(edf_pkg::CMD_LOAD, idx, shaped_value(0, 4), shaped_value(0, 24),
                  shaped_value(0, 30));
    endtask

    // every entry that takes part in a tick must hold a loaded task
    task automatic load_active_entries();
        int n;
        n = (active_lim > NTASK) ? NTASK : int'(active_lim);
        for (int i = 0; i < n; i++)
            if (!loaded[i])
                send_rand_load(4'(i));
    endtask

    task automatic test_basic_commands();
        send_item(CMD_UNUSED, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(edf_pkg::CMD_LOAD, 4'd0, 16'd2, 16'd3, 16'd3);
        repeat (4) send_tick();
        send_item(edf_pkg::CMD_RESTART, 4'hA, 16'h5555, 16'hAAAA, 16'h1234);
        send_tick();
    endtask

    task automatic test_edge_values();
        write_task_count(5'd4);
        send_item(edf_pkg::CMD_LOAD, 4'd1, 16'd0, 16'd0, 16'd0);
        send_item(edf_pkg::CMD_LOAD, 4'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(edf_pkg::CMD_LOAD, 4'd3, 16'd1, 16'd1, 16'd3);
        send_item(edf_pkg::CMD_LOAD, 4'd0, 16'd2, 16'd5, 16'd3);
        repeat (4) send_tick();
    endtask

    task automatic test_period_shrink();
        send_item(edf_pkg::CMD_LOAD, 4'd2, 16'd3, 16'd2, 16'd5);
        repeat (2) send_tick();
    endtask

    task automatic test_zero_count();
        write_task_count(5'd0);
        repeat (2) send_tick();
    endtask

    task automatic test_random_schedule();
        logic [4:0] counts[14];
        int         pick;
        counts = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd8, 5'd17, 5'd16,
                   5'd3, 5'd5, 5'd2, 5'd12, 5'd16, 5'd4, 5'd16};
        for (int ph = 0; ph < 14; ph++)
        begin
            if (ph == 13)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else if (ph % 3 == 2)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = 25;
                stall_pct = 25;
            end
            if (ph == 4 || ph == 9)
                counts[ph] = 5'($urandom_range(2, 15));
            write_task_count(counts[ph]);
            load_active_entries();
            for (int k = 0; k < 65; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    send_tick();
                else if (pick < 90)
                    send_rand_load(4'($urandom));
                else if (pick < 94)
                    send_item(edf_pkg::CMD_RESTART, 4'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom));
                else
                    send_item(CMD_UNUSED, 4'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        req_if.valid        = 1'b0;
        req_if.cmd          = edf_pkg::CMD_TICK;
        req_if.task_index   = '0;
        req_if.exec_time    = '0;
        req_if.period_len   = '0;
        req_if.rel_deadline = '0;
        for (int i = 0; i < NTASK; i++)
        begin
            exec_tab[i]   = '0;
            period_tab[i] = '0;
            dl_tab[i]     = '0;
            loaded[i]     = 1'b0;
        end
        clear_run_state();
        active_lim = edf_pkg::TASK_COUNT_RST;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_basic_commands();
        test_edge_values();
        test_period_shrink();
        test_zero_count();
        test_random_schedule();

        wait_drained();
        if (miss_count == 0 && pending_slots.size() == 0)
            $display("edf_tick_scheduler_top_test: PASS");
        else
            $display("edf_tick_scheduler_top_test: FAIL");
        $finish;
    end

endmodule
